/* hdl/pba_pkg.sv */
// ---------------------------------------------------------------------------
// pba_pkg
// shared types, constants and helpers of the page bitmap allocator
// ---------------------------------------------------------------------------
package pba_pkg;

    localparam int PBA_NUM_PAGES = 8192;   // default store size in pages
    localparam int PAGE_W        = 13;     // width of a page number field
    localparam int END_W         = 14;     // width of the range end field
    localparam int KIND_W        = 2;
    localparam int WORD_W        = 64;     // pages held in one memory word
    localparam int BIT_W         = 6;      // log2 of WORD_W
    localparam int GROUP_LSB     = 3;      // search start is rounded to groups of eight
    localparam logic [PAGE_W-1:0] SEARCH_START_RST = 13'd256;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_MARK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_ALLOC,
        ST_TEST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PAGE_W-1:0] first_page;
        logic [END_W-1:0]  end_page;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [PAGE_W-1:0] page;
        logic              page_used;
    } t_result;

    // index of the single set bit of a one-hot word
    function automatic logic [BIT_W-1:0] pba_onehot_index(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                idx = idx | BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* hdl/pba_bitmap_ram.sv */
// ---------------------------------------------------------------------------
// pba_bitmap_ram
// simple dual-port bitmap store, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module pba_bitmap_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/pba_engine.sv */
// ---------------------------------------------------------------------------
// pba_engine
// request sequencer: read-modify-write sweeps over the bitmap memory
// ---------------------------------------------------------------------------
module pba_engine #(
    parameter int NUM_PAGES = 8192
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  pba_pkg::t_req                       i_req,
    input  logic [pba_pkg::PAGE_W-1:0]          i_search_start,
    input  logic                                i_res_free,
    output logic                                o_res_valid,
    output pba_pkg::t_result                    o_res
);
    import pba_pkg::*;

    localparam int DEPTH = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = ($clog2(NUM_PAGES + 1) > END_W) ? $clog2(NUM_PAGES + 1) : END_W;
    localparam logic [CW-1:0] NUM_PAGES_C = CW'(NUM_PAGES);
    localparam logic [AW:0]   LAST_WORD   = (AW + 1)'(DEPTH - 1);
    localparam int TAIL = NUM_PAGES % WORD_W;
    // pages past the end of the store in the last word read as used
    localparam logic [WORD_W-1:0] TAIL_MASK =
        (TAIL == 0) ? '0 : ~((WORD_W'(1) << TAIL) - WORD_W'(1));
    localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

    t_state              r_state, n_state;
    logic [AW:0]         r_wcnt, n_wcnt;
    logic [AW:0]         r_stop, n_stop;
    logic [AW:0]         r_first_word, n_first_word;
    logic                r_issue_en, n_issue_en;
    logic                r_rvalid;
    logic [AW:0]         r_rword;
    logic [WORD_W-1:0]   r_first_mask, n_first_mask;
    logic [WORD_W-1:0]   r_last_mask, n_last_mask;
    logic [BIT_W-1:0]    r_bit_sel, n_bit_sel;
    t_result             r_res, n_res;

    logic                issue;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [WORD_W-1:0]   mem_wdata;
    logic [WORD_W-1:0]   mem_rdata;

    logic [CW-1:0]       first_c, end_c, end_clip, last_c, start_c;
    logic                mark_empty;
    logic [WORD_W-1:0]   mark_mask;
    logic [WORD_W-1:0]   seen, free_bits, low_free;
    logic [BIT_W-1:0]    free_idx;
    logic                free_hit;
    logic [CW-1:0]       page_c;
    logic                word_done;

    // accept-time decode
    always_comb begin
        first_c    = CW'(i_req.first_page);
        end_c      = CW'(i_req.end_page);
        end_clip   = (end_c > NUM_PAGES_C) ? NUM_PAGES_C : end_c;
        last_c     = end_clip - CW'(1);
        start_c    = CW'({i_search_start[PAGE_W-1:GROUP_LSB], GROUP_LSB'(0)});
        mark_empty = (end_clip <= first_c);
    end

    // word processing on returning read data
    always_comb begin
        mark_mask = ((r_rword == r_first_word) ? r_first_mask : ONES) &
                    ((r_rword == r_stop) ? r_last_mask : ONES);
        seen      = mem_rdata |
                    ((r_rword == r_first_word) ? ~r_first_mask : '0) |
                    ((r_rword == LAST_WORD) ? TAIL_MASK : '0);
        free_bits = ~seen;
        low_free  = free_bits & (~free_bits + WORD_W'(1));
        free_hit  = |free_bits;
        free_idx  = pba_onehot_index(low_free);
        page_c    = (CW'(r_rword) << BIT_W) | CW'(free_idx);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_wcnt == LAST_WORD) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_req.kind)
                        KIND_MARK:  n_state = mark_empty ? ST_DONE : ST_MARK;
                        KIND_ALLOC: n_state = (start_c >= NUM_PAGES_C) ? ST_DONE : ST_ALLOC;
                        KIND_TEST:  n_state = (first_c >= NUM_PAGES_C) ? ST_DONE : ST_TEST;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_MARK: begin
                if (r_rvalid && (r_rword == r_stop)) begin
                    n_state = ST_DONE;
                end
            end
            ST_ALLOC: begin
                if (r_rvalid && (free_hit || (r_rword == LAST_WORD))) begin
                    n_state = ST_DONE;
                end
            end
            ST_TEST: begin
                if (r_rvalid) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_wcnt       = r_wcnt;
        n_stop       = r_stop;
        n_first_word = r_first_word;
        n_issue_en   = r_issue_en;
        n_first_mask = r_first_mask;
        n_last_mask  = r_last_mask;
        n_bit_sel    = r_bit_sel;
        n_res        = r_res;
        issue        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_rword[AW-1:0];
        mem_wdata    = mem_rdata;
        word_done    = 1'b0;
        o_ready      = (r_state == ST_IDLE);
        o_res_valid  = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_wcnt[AW-1:0];
                mem_wdata = '0;
                n_wcnt    = r_wcnt + (AW + 1)'(1);
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_res      = '0;
                    n_issue_en = 1'b1;
                    n_stop     = LAST_WORD;
                    unique case (i_req.kind)
                        KIND_MARK: begin
                            n_first_word = (AW + 1)'(first_c >> BIT_W);
                            n_wcnt       = (AW + 1)'(first_c >> BIT_W);
                            n_stop       = (AW + 1)'(last_c >> BIT_W);
                            n_first_mask = ONES << first_c[BIT_W-1:0];
                            n_last_mask  = ONES >> (~last_c[BIT_W-1:0]);
                        end
                        KIND_ALLOC: begin
                            n_first_word = (AW + 1)'(start_c >> BIT_W);
                            n_wcnt       = (AW + 1)'(start_c >> BIT_W);
                            n_first_mask = ONES << start_c[BIT_W-1:0];
                            n_res.status = (start_c >= NUM_PAGES_C);
                        end
                        KIND_TEST: begin
                            n_first_word = (AW + 1)'(first_c >> BIT_W);
                            n_wcnt       = (AW + 1)'(first_c >> BIT_W);
                            n_stop       = (AW + 1)'(first_c >> BIT_W);
                            n_bit_sel    = first_c[BIT_W-1:0];
                        end
                        default: begin
                            n_issue_en = 1'b0;
                        end
                    endcase
                end
            end
            ST_MARK: begin
                if (r_rvalid) begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata | mark_mask;
                end
            end
            ST_ALLOC: begin
                if (r_rvalid) begin
                    if (free_hit) begin
                        mem_we       = 1'b1;
                        mem_wdata    = mem_rdata | low_free;
                        n_res.page   = page_c[PAGE_W-1:0];
                        n_res.status = 1'b0;
                        word_done    = 1'b1;
                    end else if (r_rword == LAST_WORD) begin
                        n_res.status = 1'b1;
                        n_res.page   = '0;
                        word_done    = 1'b1;
                    end
                end
            end
            ST_TEST: begin
                if (r_rvalid) begin
                    n_res.page_used = mem_rdata[r_bit_sel];
                end
            end
            ST_DONE: begin
                o_res_valid = i_res_free;
            end
            default: ;
        endcase

        // read issue runs one word ahead of the write-back
        if ((r_state == ST_MARK || r_state == ST_ALLOC || r_state == ST_TEST) &&
            r_issue_en && !word_done) begin
            issue  = 1'b1;
            n_wcnt = r_wcnt + (AW + 1)'(1);
            if (r_wcnt == r_stop) begin
                n_issue_en = 1'b0;
            end
        end
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_wcnt     <= '0;
            r_issue_en <= 1'b0;
            r_rvalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wcnt     <= n_wcnt;
            r_issue_en <= n_issue_en;
            r_rvalid   <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stop       <= n_stop;
        r_first_word <= n_first_word;
        r_first_mask <= n_first_mask;
        r_last_mask  <= n_last_mask;
        r_bit_sel    <= n_bit_sel;
        r_res        <= n_res;
        r_rword      <= r_wcnt;
    end

    pba_bitmap_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (AW),
        .DATA_W (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (issue),
        .i_raddr (r_wcnt[AW-1:0]),
        .o_rdata (mem_rdata)
    );

`ifndef SYNTHESIS
    a_no_rw_same_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && issue) |-> (mem_waddr != r_wcnt[AW-1:0]))
        else $error("read and write of the same bitmap word in one cycle");

    a_fail_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status) |-> (o_res.page == '0))
        else $error("failed allocation returns a nonzero page");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> ((r_state == ST_IDLE) && !r_rvalid))
        else $error("sequencer not idle after delivering a result");

    a_issue_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && (r_state == ST_MARK || r_state == ST_ALLOC)) |-> (r_wcnt <= r_stop))
        else $error("read issued past the last word of the sweep");
`endif

endmodule

/* hdl/page_bitmap_allocator.sv */
// ---------------------------------------------------------------------------
// page_bitmap_allocator
// first-fit physical page allocator over a one-bit-per-page bitmap memory
// ---------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  request   in         i_in_valid / o_in_ready      i_kind, i_first_page, i_end_page
//  result    out        o_out_valid / i_out_ready    o_status, o_page, o_page_used
//  config    in         i_cfg_we (no wait)           i_cfg_wdata (search start page)
//
//  memory: the bitmap sits in 64-page memory words, one word read and one
//  written per cycle; mark sweeps the words it touches, allocate scans from
//  the search start towards the last word and stops at the first free page,
//  test reads the one word that holds its page; reset: a clearing pass
//  writes every word to zero, with o_in_ready low throughout
//  stalls: a finished result waits in the output register, so the next
//  item is taken while the previous result is still unclaimed
// ---------------------------------------------------------------------------
module page_bitmap_allocator #(
    parameter int NUM_PAGES = pba_pkg::PBA_NUM_PAGES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [pba_pkg::KIND_W-1:0]   i_kind,
    input  logic [pba_pkg::PAGE_W-1:0]   i_first_page,
    input  logic [pba_pkg::END_W-1:0]    i_end_page,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_status,
    output logic [pba_pkg::PAGE_W-1:0]   o_page,
    output logic                         o_page_used,
    // search start register
    input  logic                         i_cfg_we,
    input  logic [pba_pkg::PAGE_W-1:0]   i_cfg_wdata
);
    import pba_pkg::*;

    logic [PAGE_W-1:0] r_search_start;
    logic              r_out_valid;
    t_result           r_out;

    t_req              req;
    t_result           res;
    logic              res_valid;
    logic              res_free;

    // search start register, low three bits ignored by the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_start <= SEARCH_START_RST;
        end else if (i_cfg_we) begin
            r_search_start <= i_cfg_wdata;
        end
    end

    assign req.kind       = i_kind;
    assign req.first_page = i_first_page;
    assign req.end_page   = i_end_page;

    // output slot is free when empty or being emptied this cycle
    assign res_free = !r_out_valid || i_out_ready;

    pba_engine #(
        .NUM_PAGES (NUM_PAGES)
    ) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_req          (req),
        .i_search_start (r_search_start),
        .i_res_free     (res_free),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    // result output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out.status;
    assign o_page      = r_out.page;
    assign o_page_used = r_out.page_used;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> (!r_out_valid || i_out_ready))
        else $error("result written over an unclaimed item");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("unclaimed result dropped");

    a_new_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(res_valid))
        else $error("output became valid without a finished request");
`endif

endmodule

/* dv/page_bitmap_allocator_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// page_bitmap_allocator_tb
// self-checking bench for the first-fit page bitmap allocator
// ---------------------------------------------------------------------------
//  requests are queued up front by the stimulus builder: a short directed
//  list (empty and clipped ranges, full groups, exhausted search window,
//  unused kind) followed by random phases, each opened by a search start
//  write once the allocator has drained. a clocked driver pushes them in
//  bursts and keeps a bit-accurate copy of the page map, so every accepted
//  item yields one predicted result; a clocked monitor stalls the result
//  side on a rotating pattern and checks each result field by field
// ---------------------------------------------------------------------------
module page_bitmap_allocator_tb;
    import pba_pkg::*;

    localparam int PAGES          = PBA_NUM_PAGES;
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int IDLE_LIMIT     = 3000;  // clear pass, full scan and longest stall fit many times
    localparam int DRAIN_CYCLES   = 200;   // beyond a full allocate scan
    localparam int RANDOM_PHASES  = 16;
    localparam int PHASE_ITEMS    = 67;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;  // unused kind, must do nothing

    // one queued command: either a request item or a search start write
    typedef struct {
        bit                is_cfg;
        logic [PAGE_W-1:0] cfg_value;
        logic [KIND_W-1:0] kind;
        logic [PAGE_W-1:0] first_page;
        logic [END_W-1:0]  end_page;
    } t_page_cmd;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [KIND_W-1:0]   i_kind;
    logic [PAGE_W-1:0]   i_first_page;
    logic [END_W-1:0]    i_end_page;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_status;
    logic [PAGE_W-1:0]   o_page;
    logic                o_page_used;
    logic                i_cfg_we;
    logic [PAGE_W-1:0]   i_cfg_wdata;

    // predictor state: our own copy of the page map and search start
    bit [PAGES-1:0]      used_pages;
    logic [PAGE_W-1:0]   search_start_copy;

    t_page_cmd           cmd_queue[$];
    t_result             expected_results[$];

    int                  burst_left;
    int                  gap_left;
    logic [31:0]         ready_pattern;
    int                  pattern_age;
    int                  idle_cycles;

    int                  mismatch_count;
    int                  results_checked;
    int                  n_marks;
    int                  n_allocs;
    int                  n_alloc_full;
    int                  n_tests;
    int                  n_test_used;
    int                  n_spare;
    int                  n_cfg_writes;

    page_bitmap_allocator u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_first_page (i_first_page),
        .i_end_page   (i_end_page),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_page       (o_page),
        .o_page_used  (o_page_used),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // predictor: applies one request to the page map copy and returns the
    // result the allocator must give for it
    // -----------------------------------------------------------------------
    function automatic t_result predict_page_request(input logic [KIND_W-1:0] kind,
                                                     input logic [PAGE_W-1:0] first,
                                                     input logic [END_W-1:0]  last_excl);
        t_result     res;
        int unsigned stop;
        int unsigned p;
        bit          found;
        res   = '0;
        found = 1'b0;
        case (kind)
            KIND_MARK: begin
                // range clipped to the store, empty when end is not past first
                stop = (int'(last_excl) > PAGES) ? PAGES : last_excl;
                for (p = first; p < stop; p++) begin
                    used_pages[p] = 1'b1;
                end
            end
            KIND_ALLOC: begin
                // first free page from the group-aligned start; skipping full
                // groups cannot change which page is lowest
                for (p = {search_start_copy[PAGE_W-1:GROUP_LSB], {GROUP_LSB{1'b0}}};
                     p < PAGES && !found; p++) begin
                    if (!used_pages[p]) begin
                        used_pages[p] = 1'b1;
                        res.page      = PAGE_W'(p);
                        found         = 1'b1;
                    end
                end
                // window exhausted: failure, page 0, nothing marked
                if (!found) begin
                    res.status = 1'b1;
                end
            end
            KIND_TEST: begin
                res.page_used = used_pages[first];
            end
            default: begin
                // spare kind leaves the map alone and returns all zeros
            end
        endcase
        return res;
    endfunction

    task automatic queue_request(input logic [KIND_W-1:0] kind, input int first,
                                 input int last_excl);
        t_page_cmd c;
        c            = '{default: '0};
        c.kind       = kind;
        c.first_page = PAGE_W'(first);
        c.end_page   = END_W'(last_excl);
        cmd_queue.push_back(c);
    endtask

    // a search start write; the driver holds it back until nothing is in flight
    task automatic queue_search_start(input int value);
        t_page_cmd c;
        c           = '{default: '0};
        c.is_cfg    = 1'b1;
        c.cfg_value = PAGE_W'(value);
        cmd_queue.push_back(c);
    endtask

    // one random phase: most traffic lands near the search start so that
    // allocations, marks and tests all hit the same pages
    task automatic queue_random_phase(input int start_value, input int count);
        int base;
        int near_page;
        int first;
        int pick;
        int shape;
        base = start_value & ~7;
        queue_search_start(start_value);
        for (int i = 0; i < count; i++) begin
            pick      = $urandom_range(0, 99);
            near_page = base + $urandom_range(0, 95);
            if (near_page > PAGES - 1) begin
                near_page = PAGES - 1;
            end
            first = $urandom_range(0, 1) ? near_page : $urandom_range(0, PAGES - 1);
            if (pick < 45) begin
                // allocate with junk in the fields it ignores
                queue_request(KIND_ALLOC, $urandom_range(0, PAGES - 1), $urandom_range(0, 16383));
            end else if (pick < 75) begin
                queue_request(KIND_TEST, first, $urandom_range(0, 16383));
            end else if (pick < 95) begin
                shape = $urandom_range(0, 19);
                if (shape == 0) begin
                    // empty range, end at or below first
                    queue_request(KIND_MARK, first,
                                  first - $urandom_range(0, (first < 30) ? first : 30));
                end else if (shape == 1) begin
                    // near the top with any end: mostly clipped or empty
                    queue_request(KIND_MARK, $urandom_range(8000, PAGES - 1),
                                  $urandom_range(0, 16383));
                end else if (shape == 2) begin
                    queue_request(KIND_MARK, first, first + $urandom_range(0, 400));
                end else begin
                    queue_request(KIND_MARK, first, first + $urandom_range(1, 12));
                end
            end else begin
                queue_request(KIND_SPARE, $urandom_range(0, PAGES - 1), $urandom_range(0, 16383));
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // request driver: predicts on every accepted item, then loads the next
    // command once the burst/gap schedule allows
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : request_driver
        logic      take;
        logic      valid_nxt;
        logic      we_nxt;
        t_page_cmd cmd;
        t_result   res;
        take      = i_in_valid && o_in_ready;
        valid_nxt = i_in_valid && !take;
        we_nxt    = 1'b0;
        if (i_rst_n) begin
            if (take) begin
                res = predict_page_request(i_kind, i_first_page, i_end_page);
                expected_results.push_back(res);
                case (i_kind)
                    KIND_MARK:  n_marks++;
                    KIND_ALLOC: begin
                        n_allocs++;
                        n_alloc_full += res.status;
                    end
                    KIND_TEST:  begin
                        n_tests++;
                        n_test_used += res.page_used;
                    end
                    default:    n_spare++;
                endcase
            end
            if (!valid_nxt && gap_left > 0) begin
                gap_left--;
            end else if (!valid_nxt && cmd_queue.size() > 0) begin
                cmd = cmd_queue[0];
                if (cmd.is_cfg) begin
                    // register only written with the allocator fully drained
                    if (expected_results.size() == 0 && !i_cfg_we) begin
                        void'(cmd_queue.pop_front());
                        we_nxt            = 1'b1;
                        i_cfg_wdata       <= cmd.cfg_value;
                        search_start_copy = cmd.cfg_value;
                        n_cfg_writes++;
                    end
                end else begin
                    void'(cmd_queue.pop_front());
                    valid_nxt    = 1'b1;
                    i_kind       <= cmd.kind;
                    i_first_page <= cmd.first_page;
                    i_end_page   <= cmd.end_page;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // new burst; a quarter of the time no gap at all
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
        i_in_valid <= valid_nxt;
        i_cfg_we   <= we_nxt;
    end

    // -----------------------------------------------------------------------
    // result monitor: oldest prediction against each accepted result, and
    // the ready stall pattern, re-chosen whenever pattern_age wraps to zero
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                $display("%0t: result with no request pending: status %0d page %0d used %0d",
                         $time, o_status, o_page, o_page_used);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    mismatch_count++;
                end
                if (o_page !== want.page) begin
                    $display("%0t: page expected %0d actual %0d", $time, want.page, o_page);
                    mismatch_count++;
                end
                if (o_page_used !== want.page_used) begin
                    $display("%0t: page_used expected %0d actual %0d",
                             $time, want.page_used, o_page_used);
                    mismatch_count++;
                end
            end
        end
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = '1;                    // no stalls
                1:       ready_pattern = $urandom;              // even mix
                2:       ready_pattern = $urandom & $urandom;   // mostly stalled
                default: ready_pattern = $urandom | $urandom;   // mostly ready
            endcase
        end else begin
            ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
        end
        pattern_age = (pattern_age + 1) % 64;
        i_out_ready <= ready_pattern[0];
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin : stall_watchdog
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, expected_results.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int start_value;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_kind            = KIND_MARK;
        i_first_page      = '0;
        i_end_page        = '0;
        i_out_ready       = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        used_pages        = '0;
        search_start_copy = SEARCH_START_RST;
        burst_left        = 0;
        gap_left          = 0;
        ready_pattern     = '1;
        pattern_age       = 0;
        idle_cycles       = 0;
        mismatch_count    = 0;
        results_checked   = 0;
        n_marks           = 0;
        n_allocs          = 0;
        n_alloc_full      = 0;
        n_tests           = 0;
        n_test_used       = 0;
        n_spare           = 0;
        n_cfg_writes      = 0;

        // directed part, search start still at its reset value
        queue_request(KIND_TEST, 0, 0);                 // store starts all free
        queue_request(KIND_TEST, PAGES - 1, 0);
        queue_request(KIND_MARK, 100, 100);             // empty range
        queue_request(KIND_MARK, 200, 50);              // end below first
        queue_request(KIND_MARK, 0, 0);
        queue_request(KIND_ALLOC, 0, 0);                // first page of the window
        queue_request(KIND_ALLOC, PAGES - 1, 16383);    // ignored fields all ones
        queue_request(KIND_MARK, 258, 264);             // fills the first group
        queue_request(KIND_MARK, 264, 272);             // and the next one
        queue_request(KIND_ALLOC, 0, 0);                // skips both full groups
        queue_request(KIND_TEST, 257, 0);
        queue_request(KIND_TEST, 263, 0);
        queue_request(KIND_TEST, 273, 16383);
        queue_request(KIND_MARK, 8190, 16383);          // clipped to the store
        queue_request(KIND_TEST, PAGES - 1, 0);
        queue_request(KIND_SPARE, PAGES - 1, 16383);    // spare kind
        queue_request(KIND_SPARE, 0, 0);
        // highest start, rounds down to the last group
        queue_search_start(PAGES - 1);
        queue_request(KIND_ALLOC, 0, 0);
        queue_request(KIND_MARK, 8185, 8190);           // last group now full
        queue_request(KIND_ALLOC, 0, 0);                // nothing free left
        queue_request(KIND_TEST, 8184, 0);
        queue_search_start(0);
        queue_request(KIND_ALLOC, 0, 0);
        queue_request(KIND_TEST, 0, 0);

        // random phases, each opened by a drain and a search start write
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                start_value = 0;
            end else if (ph == 2) begin
                start_value = PAGES - 1;
            end else if (ph == 3) begin
                start_value = SEARCH_START_RST;
            end else if (ph % 5 == 1) begin
                start_value = $urandom_range(8100, PAGES - 1);   // small window, fills up
            end else begin
                start_value = $urandom_range(0, PAGES - 1);
            end
            queue_random_phase(start_value, PHASE_ITEMS);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all items handed over, then every result back, then a quiet spell
        do @(posedge i_clk); while (cmd_queue.size() != 0 || i_in_valid);
        do @(posedge i_clk); while (expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run covered %0d marks, %0d allocations (%0d with no free page), %0d tests",
                 n_marks, n_allocs, n_alloc_full, n_tests);
        $display("%0d tests saw a used page, %0d spare kind, %0d start writes, %0d results",
                 n_test_used, n_spare, n_cfg_writes, results_checked);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
